// ===== hdl/sscr_pkg.sv =====
// Package for the serial slave command register unit.
// Holds the bus event codes, reply codes, command codes and the queue entry type.
// No dependencies.
package sscr_pkg;

    localparam int BUFFER_DEPTH_DEF = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] ACT_ADDRESSED = 3'd0;
    localparam logic [2:0] ACT_DATA      = 3'd1;
    localparam logic [2:0] ACT_STOP      = 3'd2;
    localparam logic [2:0] ACT_RESPOND   = 3'd3;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NACK = 2'd2;
    localparam logic [1:0] REPLY_SEND = 2'd3;

    localparam logic [7:0] CMD_READ_MOISTURE = 8'h01;
    localparam logic [7:0] CMD_READ_SAMPLES  = 8'h02;
    localparam logic [7:0] CMD_READ_LOW      = 8'h03;
    localparam logic [7:0] CMD_READ_HIGH     = 8'h04;
    localparam logic [7:0] CMD_WRITE_SAMPLES = 8'h05;
    localparam logic [7:0] CMD_WRITE_LOW     = 8'h06;
    localparam logic [7:0] CMD_WRITE_HIGH    = 8'h07;
    localparam logic [7:0] CMD_PUMP          = 8'h08;

    typedef enum logic [2:0] {
        OP_ADDR,
        OP_DATA,
        OP_STOP,
        OP_RESPOND,
        OP_OTHER
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic [7:0] moisture_now;
    } t_entry;

endpackage

// ===== hdl/sscr_if.sv =====
// Request and result channel interfaces for the serial slave command register unit.
// Valid/ready handshake with the payload fields; no dependencies.
interface sscr_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [7:0] moisture_now;

    modport source (output valid, output action, output data_byte, output moisture_now,
                    input ready);
    modport sink (input valid, input action, input data_byte, input moisture_now,
                  output ready);
endinterface

interface sscr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] bus_reply;
    logic [7:0] reply_byte;
    logic       pump_start;

    modport source (output valid, output bus_reply, output reply_byte, output pump_start,
                    input ready);
    modport sink (input valid, input bus_reply, input reply_byte, input pump_start,
                  output ready);
endinterface

// ===== hdl/serial_slave_command_register_unit.sv =====
// Serial slave command register unit, top level.
// A request is written into the queue; the back end registers its result when popping it.
// Throughput: the back end executes one request per cycle while o_rsp.ready stays high.
// The queue holds two requests, so input and output stall independently.
// Reset (synchronous, active low) clears the buffer, fill index, pending mark and settings.
// Depends on sscr_pkg, sscr_if, sscr_front, sscr_queue and sscr_back.
module serial_slave_command_register_unit
    import sscr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sscr_in_if.sink    i_req,
    sscr_out_if.source o_rsp
);

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry wr_entry;
    t_entry rd_entry;

    sscr_front u_front (
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_entry (wr_entry)
    );

    sscr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (wr_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_entry (rd_entry)
    );

    sscr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (rd_entry),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== hdl/sscr_front.sv =====
// Front end: accepts bus event requests and classifies them into queue entries.
// Depends on sscr_pkg and sscr_in_if.
module sscr_front
    import sscr_pkg::*;
(
    sscr_in_if.sink i_req,
    input  logic    i_full,
    output logic    o_push,
    output t_entry  o_entry
);

    t_op op;

    always_comb begin
        unique case (i_req.action)
            ACT_ADDRESSED: op = OP_ADDR;
            ACT_DATA:      op = OP_DATA;
            ACT_STOP:      op = OP_STOP;
            ACT_RESPOND:   op = OP_RESPOND;
            default:       op = OP_OTHER;
        endcase
    end

    assign i_req.ready          = !i_full;
    assign o_push               = i_req.valid && !i_full;
    assign o_entry.op           = op;
    assign o_entry.data_byte    = i_req.data_byte;
    assign o_entry.moisture_now = i_req.moisture_now;

endmodule

// ===== hdl/sscr_queue.sv =====
// Short queue between the front end and the back end.
// Depends on sscr_pkg for the entry type and default depth.
module sscr_queue
    import sscr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/sscr_back.sv =====
// Back end: carries out queued bus events, holds the command buffer and settings,
// and registers one result per event. Depends on sscr_pkg and sscr_out_if.
module sscr_back
    import sscr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_entry   i_entry,
    output logic     o_pop,
    sscr_out_if.source o_rsp
);

    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]    r_buffer [BUFFER_DEPTH];
    logic [FW-1:0] r_fill;
    logic          r_pending;
    logic [7:0]    r_samples;
    logic [7:0]    r_low;
    logic [7:0]    r_high;
    logic          r_valid;
    logic [1:0]    r_reply;
    logic [7:0]    r_byte;
    logic          r_pump;

    logic [1:0]    n_reply;
    logic [7:0]    n_byte;
    logic          n_pump;
    logic          room;

    assign room  = (r_fill < FW'(BUFFER_DEPTH));
    assign o_pop = !i_empty && (!r_valid || o_rsp.ready);

    always_comb begin
        n_reply = REPLY_NACK;
        n_byte  = '0;
        n_pump  = 1'b0;
        unique case (i_entry.op)
            OP_ADDR: n_reply = REPLY_ACK;
            OP_DATA: n_reply = room ? REPLY_ACK : REPLY_NACK;
            OP_STOP: n_reply = REPLY_ACK;
            OP_RESPOND: begin
                if (!r_pending) begin
                    n_reply = REPLY_NONE;
                end else begin
                    unique case (r_buffer[0]) inside
                        CMD_READ_MOISTURE: begin
                            n_reply = REPLY_SEND;
                            n_byte  = i_entry.moisture_now;
                        end
                        CMD_READ_SAMPLES: begin
                            n_reply = REPLY_SEND;
                            n_byte  = r_samples;
                        end
                        CMD_READ_LOW: begin
                            n_reply = REPLY_SEND;
                            n_byte  = r_low;
                        end
                        CMD_READ_HIGH: begin
                            n_reply = REPLY_SEND;
                            n_byte  = r_high;
                        end
                        CMD_WRITE_SAMPLES, CMD_WRITE_LOW, CMD_WRITE_HIGH: n_reply = REPLY_ACK;
                        CMD_PUMP: begin
                            n_reply = REPLY_ACK;
                            n_pump  = 1'b1;
                        end
                        default: n_reply = REPLY_NACK;
                    endcase
                end
            end
            default: n_reply = REPLY_NACK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                r_buffer[i] <= '0;
            end
            r_fill    <= '0;
            r_pending <= 1'b0;
            r_samples <= '0;
            r_low     <= '0;
            r_high    <= '0;
            r_valid   <= 1'b0;
            r_reply   <= REPLY_NONE;
            r_byte    <= '0;
            r_pump    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_reply <= n_reply;
                r_byte  <= n_byte;
                r_pump  <= n_pump;
                unique case (i_entry.op)
                    OP_ADDR: r_fill <= '0;
                    OP_DATA: begin
                        if (room) begin
                            r_buffer[r_fill[IW-1:0]] <= i_entry.data_byte;
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                    OP_STOP: r_pending <= 1'b1;
                    OP_RESPOND: begin
                        if (r_pending) begin
                            r_pending <= 1'b0;
                            if (r_buffer[0] == CMD_WRITE_SAMPLES) begin
                                r_samples <= r_buffer[1];
                            end
                            if (r_buffer[0] == CMD_WRITE_LOW) begin
                                r_low <= r_buffer[1];
                            end
                            if (r_buffer[0] == CMD_WRITE_HIGH) begin
                                r_high <= r_buffer[1];
                            end
                        end
                    end
                    default: ;
                endcase
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.bus_reply  = r_reply;
    assign o_rsp.reply_byte = r_byte;
    assign o_rsp.pump_start = r_pump;

endmodule

// ===== tb/tb_serial_slave_command_register_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the serial slave command register unit: directed table, then random bus events.
// Checks replies against typed rows or a local model; needs sscr_pkg, sscr_if and the RTL.
module tb_serial_slave_command_register_unit
    import sscr_pkg::*;
();

    localparam logic [2:0] ACT_STATUS = 3'd4;
    localparam logic [2:0] ACT_LAST   = 3'd7;
    localparam int DIRECTED_ROWS   = 25;
    localparam int RANDOM_REQUESTS = 1600;
    localparam int PRESSURE_AT     = 600;
    localparam int HOLD_CYCLES     = 40;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic [1:0] reply;
        logic [7:0] byte_out;
        logic       pump;
    } t_reply;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic [7:0] moisture_now;
        logic       typed;
        t_reply     exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sscr_in_if  req_if ();
    sscr_out_if rsp_if ();

    serial_slave_command_register_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #6 i_clk = ~i_clk;

    logic [7:0] cmd_bytes [BUFFER_DEPTH_DEF];
    int         fill_count = 0;
    logic       cmd_armed = 1'b0;
    logic [7:0] set_samples = 8'h00;
    logic [7:0] set_low = 8'h00;
    logic [7:0] set_high = 8'h00;

    t_reply reply_queue [$];
    int     errors = 0;
    int     requests_sent = 0;
    int     cycle_count = 0;
    bit     no_idle = 1'b0;
    bit     hold_request = 1'b0;

    // Rows marked typed carry an expected reply that follows directly from the command table.
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{ACT_RESPOND,   8'h00,             8'h00, 1'b1, '{REPLY_NONE, 8'h00, 1'b0}},
        '{ACT_STATUS,    8'hFF,             8'hFF, 1'b1, '{REPLY_NACK, 8'h00, 1'b0}},
        '{ACT_LAST,      8'h00,             8'h00, 1'b1, '{REPLY_NACK, 8'h00, 1'b0}},
        '{ACT_STOP,      8'h00,             8'h00, 1'b1, '{REPLY_ACK,  8'h00, 1'b0}},
        '{ACT_RESPOND,   8'h00,             8'h7F, 1'b1, '{REPLY_NACK, 8'h00, 1'b0}},
        '{ACT_ADDRESSED, 8'h00,             8'h00, 1'b1, '{REPLY_ACK,  8'h00, 1'b0}},
        '{ACT_DATA,      CMD_WRITE_LOW,     8'h00, 1'b1, '{REPLY_ACK,  8'h00, 1'b0}},
        '{ACT_DATA,      8'hFF,             8'h00, 1'b1, '{REPLY_ACK,  8'h00, 1'b0}},
        '{ACT_DATA,      8'h00,             8'h00, 1'b1, '{REPLY_ACK,  8'h00, 1'b0}},
        '{ACT_DATA,      8'hAA,             8'h00, 1'b1, '{REPLY_ACK,  8'h00, 1'b0}},
        '{ACT_DATA,      8'h55,             8'h00, 1'b1, '{REPLY_NACK, 8'h00, 1'b0}},
        '{ACT_STOP,      8'h00,             8'h00, 1'b1, '{REPLY_ACK,  8'h00, 1'b0}},
        '{ACT_RESPOND,   8'h00,             8'h00, 1'b0, '0},
        '{ACT_ADDRESSED, 8'h00,             8'h00, 1'b0, '0},
        '{ACT_DATA,      CMD_READ_LOW,      8'h00, 1'b0, '0},
        '{ACT_STOP,      8'h00,             8'h00, 1'b0, '0},
        '{ACT_RESPOND,   8'h00,             8'h00, 1'b0, '0},
        '{ACT_ADDRESSED, 8'h00,             8'h00, 1'b0, '0},
        '{ACT_DATA,      CMD_READ_MOISTURE, 8'h00, 1'b0, '0},
        '{ACT_STOP,      8'h00,             8'h00, 1'b0, '0},
        '{ACT_RESPOND,   8'h00,             8'hFF, 1'b0, '0},
        '{ACT_ADDRESSED, 8'h00,             8'h00, 1'b0, '0},
        '{ACT_DATA,      CMD_PUMP,          8'h00, 1'b0, '0},
        '{ACT_STOP,      8'h00,             8'h00, 1'b0, '0},
        '{ACT_RESPOND,   8'h00,             8'h00, 1'b0, '0}
    };

    function automatic t_reply compute_bus_reply(input logic [2:0] act, input logic [7:0] db,
                                                 input logic [7:0] mo);
        t_reply r;
        r = '{reply: REPLY_NACK, byte_out: 8'h00, pump: 1'b0};
        case (act)
            ACT_ADDRESSED: begin
                fill_count = 0;
                r.reply = REPLY_ACK;
            end
            ACT_DATA: begin
                if (fill_count < BUFFER_DEPTH_DEF) begin
                    cmd_bytes[fill_count] = db;
                    fill_count++;
                    r.reply = REPLY_ACK;
                end
            end
            ACT_STOP: begin
                cmd_armed = 1'b1;
                r.reply = REPLY_ACK;
            end
            ACT_RESPOND: begin
                if (!cmd_armed) begin
                    r.reply = REPLY_NONE;
                end else begin
                    cmd_armed = 1'b0;
                    case (cmd_bytes[0])
                        CMD_READ_MOISTURE: begin r.reply = REPLY_SEND; r.byte_out = mo; end
                        CMD_READ_SAMPLES: begin r.reply = REPLY_SEND; r.byte_out = set_samples; end
                        CMD_READ_LOW: begin r.reply = REPLY_SEND; r.byte_out = set_low; end
                        CMD_READ_HIGH: begin r.reply = REPLY_SEND; r.byte_out = set_high; end
                        CMD_WRITE_SAMPLES: begin set_samples = cmd_bytes[1]; r.reply = REPLY_ACK; end
                        CMD_WRITE_LOW: begin set_low = cmd_bytes[1]; r.reply = REPLY_ACK; end
                        CMD_WRITE_HIGH: begin set_high = cmd_bytes[1]; r.reply = REPLY_ACK; end
                        CMD_PUMP: begin r.pump = 1'b1; r.reply = REPLY_ACK; end
                        default: r.reply = REPLY_NACK;
                    endcase
                end
            end
            default: r.reply = REPLY_NACK;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_request(input logic [2:0] act, input logic [7:0] db,
                                input logic [7:0] mo, input bit typed = 1'b0,
                                input t_reply typed_reply = '0);
        int     gap;
        t_reply predicted;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.action       <= act;
        req_if.data_byte    <= db;
        req_if.moisture_now <= mo;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = compute_bus_reply(act, db, mo);
        reply_queue.push_back(typed ? typed_reply : predicted);
        requests_sent++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_replies
        t_reply exp;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("serial_slave_command_register_unit verification failed");
            $finish;
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (reply_queue.size() == 0) begin
                $error("reply with no request outstanding: bus_reply %0d", rsp_if.bus_reply);
                errors++;
            end else begin
                exp = reply_queue.pop_front();
                if (rsp_if.bus_reply !== exp.reply) begin
                    $error("bus_reply expected %0d actual %0d", exp.reply, rsp_if.bus_reply);
                    errors++;
                end
                if (rsp_if.reply_byte !== exp.byte_out) begin
                    $error("reply_byte expected %0h actual %0h", exp.byte_out, rsp_if.reply_byte);
                    errors++;
                end
                if (rsp_if.pump_start !== exp.pump) begin
                    $error("pump_start expected %0b actual %0b", exp.pump, rsp_if.pump_start);
                    errors++;
                end
            end
        end
    end

    // The long hold lets the internal queue fill so that the request side stalls.
    initial begin : drive_ready
        int stall;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int         kind;
        int         len;
        logic [7:0] code;
        bit         pressure_done;
        pressure_done       = 1'b0;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.action       = ACT_ADDRESSED;
        req_if.data_byte    = 8'h00;
        req_if.moisture_now = 8'h00;
        foreach (cmd_bytes[i]) cmd_bytes[i] = 8'h00;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].action, directed_rows[i].data_byte,
                         directed_rows[i].moisture_now, directed_rows[i].typed,
                         directed_rows[i].exp);
        end

        while (requests_sent < DIRECTED_ROWS + RANDOM_REQUESTS) begin
            if (!pressure_done && requests_sent > PRESSURE_AT) begin
                hold_request  = 1'b1;
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                send_request(ACT_ADDRESSED, random_byte(), random_byte());
                len = $urandom_range(0, BUFFER_DEPTH_DEF + 1);
                for (int i = 0; i < len; i++) begin
                    if (i == 0 && $urandom_range(0, 6) != 0)
                        code = 8'($urandom_range(CMD_READ_MOISTURE, CMD_PUMP));
                    else
                        code = random_byte();
                    send_request(ACT_DATA, code, random_byte());
                end
                send_request(ACT_STOP, random_byte(), random_byte());
                send_request(ACT_RESPOND, random_byte(), random_byte());
                if ($urandom_range(0, 4) == 0)
                    send_request(ACT_RESPOND, random_byte(), random_byte());
            end else if (kind < 9) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    send_request(3'($urandom_range(ACT_ADDRESSED, ACT_RESPOND)),
                                 ($urandom_range(0, 1) != 0)
                                     ? 8'($urandom_range(CMD_READ_MOISTURE, CMD_PUMP))
                                     : random_byte(),
                                 random_byte());
                end
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) begin
                    send_request(3'($urandom_range(ACT_STATUS, ACT_LAST)), random_byte(),
                                 random_byte());
                end
            end
        end
        req_if.valid <= 1'b0;

        while (reply_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("serial_slave_command_register_unit verification clean");
        end else begin
            $display("serial_slave_command_register_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== serial_slave_command_register_unit.f =====
hdl/sscr_pkg.sv
hdl/sscr_if.sv
hdl/sscr_front.sv
hdl/sscr_queue.sv
hdl/sscr_back.sv
hdl/serial_slave_command_register_unit.sv
tb/tb_serial_slave_command_register_unit.sv
